@@ rtl/qbls_pkg.sv @@
package qbls_pkg;

  localparam int FRAC_BITS = 16;

  // coordinate and edge components
  localparam int CO_W   = 32;
  localparam int NPT    = 4;
  localparam int IN_W   = 3 * NPT * CO_W;

  // cross components after the fraction shift, and their squares
  localparam int CR_W   = 2 * CO_W - FRAC_BITS;
  localparam int HL     = CR_W / 2;
  localparam int HH     = CR_W - HL;
  localparam int SUM_W  = 2 * CR_W;
  localparam int TR_W   = SUM_W + 2;
  localparam int RT_W   = CR_W;
  localparam int DT_W   = CR_W + 1;

  // cotangent, stiffness vector and entries
  localparam int COT_W  = CO_W - 1;
  localparam int K_W    = CO_W + 1;
  localparam int KA_W   = K_W;
  localparam int PR_W   = 2 * KA_W;
  localparam int ENT_W  = 48;
  localparam int NENT   = 10;
  localparam int OUT_W  = NENT * ENT_W;

  // divider, used for the cotangents and the entries
  localparam int Q_W     = ENT_W - 1;
  localparam int NUM_W   = PR_W + 2;
  localparam int AR_W    = RT_W + 1;
  localparam int DEN_W   = AR_W;
  localparam int DIV_LAT = Q_W + 1;

  // front stages, sqrt, divider, middle stages, divider, output register
  localparam int LAT = 5 + RT_W + DIV_LAT + 5 + DIV_LAT + 1;

  // edge table: e0, e1, e2, e3, e4, n0 as (from, to)
  localparam int EDGE_FROM [6] = '{0, 0, 0, 1, 1, 1};
  localparam int EDGE_TO   [6] = '{1, 2, 3, 2, 3, 0};

  // cotangent pairs: (e0,e1) (e0,e2) (n0,e3) (n0,e4)
  localparam int PAIR_A [4] = '{0, 0, 5, 5};
  localparam int PAIR_B [4] = '{1, 2, 3, 4};

  localparam int NX1 [3] = '{1, 2, 0};
  localparam int NX2 [3] = '{2, 0, 1};

  // lower triangle entries in output order
  localparam int ENT_ROW [NENT] = '{0, 1, 1, 2, 2, 2, 3, 3, 3, 3};
  localparam int ENT_COL [NENT] = '{0, 0, 1, 0, 1, 2, 0, 1, 2, 3};

  function automatic logic signed [CO_W-1:0] sat_co(logic signed [CO_W:0] v);
    logic signed [CO_W-1:0] r;
    if (v[CO_W] != v[CO_W-1]) begin
      r = v[CO_W] ? {1'b1, {(CO_W-1){1'b0}}} : {1'b0, {(CO_W-1){1'b1}}};
    end else begin
      r = v[CO_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/quadratic_bending_local_stiffness.sv @@
// quadratic bending stiffness of one triangle pair sharing edge p0-p1
//
// input stream: one beat carries the four vertices p0..p3, twelve signed
// Q15.16 coordinates. output stream: one beat carries the ten distinct
// entries of the symmetric 4x4 stiffness matrix as signed Q31.16 values,
// saturated, plus a degenerate flag that forces all entries to zero.
//
// the block is one stall-together pipeline: a new beat is taken every cycle
// unless the output stalls. a beat passes 5 front stages, 48 square root
// stages, a 48 stage cotangent divider, 5 stages for K and its products,
// a 48 stage entry divider and the output register, LAT stages in all. the bit
// serial square root and the restoring dividers make up most of that depth.
//
// when m_axis_tready is low while a result is shown, every stage holds and
// s_axis_tready drops; nothing is lost or repeated. reset clears only the
// valid bits, so the pipeline comes up empty and takes a beat at once.
module quadratic_bending_local_stiffness import qbls_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // p0_x, p0_y, p0_z, p1_x, ... p3_z, 32 bits each
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // q_00, q_10, q_11, q_20, q_21, q_22, q_30, q_31, q_32, q_33, 48 bits each
  output logic [OUT_W-1:0] m_axis_tdata,
  // degenerate
  output logic             m_axis_tuser
);

  logic           en;
  logic [LAT-1:0] vld_q;

  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // stage 1: saturated edge vectors
  logic signed [CO_W-1:0] pt     [NPT][3];
  logic signed [CO_W-1:0] edge_q [6][3];

  always_comb begin
    for (int p = 0; p < NPT; p++) begin
      for (int a = 0; a < 3; a++) begin
        pt[p][a] = s_axis_tdata[CO_W*(p*3+a) +: CO_W];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int e = 0; e < 6; e++) begin
        for (int a = 0; a < 3; a++) begin
          edge_q[e][a] <= sat_co(K_W'(pt[EDGE_TO[e]][a]) - K_W'(pt[EDGE_FROM[e]][a]));
        end
      end
    end
  end

  // stage 2: cross and dot partial products
  logic signed [2*CO_W-1:0] cpos_q [4][3];
  logic signed [2*CO_W-1:0] cneg_q [4][3];
  logic signed [2*CO_W-1:0] dp_q   [4][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int p = 0; p < 4; p++) begin
        for (int k = 0; k < 3; k++) begin
          cpos_q[p][k] <= edge_q[PAIR_A[p]][NX1[k]] * edge_q[PAIR_B[p]][NX2[k]];
          cneg_q[p][k] <= edge_q[PAIR_A[p]][NX2[k]] * edge_q[PAIR_B[p]][NX1[k]];
          dp_q[p][k]   <= edge_q[PAIR_A[p]][k] * edge_q[PAIR_B[p]][k];
        end
      end
    end
  end

  // stage 3: floored cross components and dot products
  logic signed [CR_W-1:0]   cr_q  [4][3];
  logic signed [DT_W-1:0]   dot_q [4];
  logic signed [2*CO_W-1:0] cdif  [4][3];
  logic signed [2*CO_W-1:0] csh   [4][3];
  logic signed [2*CO_W-1:0] dsh   [4][3];
  logic signed [DT_W-1:0]   dsum  [4];

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      dsum[p] = '0;
      for (int k = 0; k < 3; k++) begin
        cdif[p][k] = cpos_q[p][k] - cneg_q[p][k];
        csh[p][k]  = cdif[p][k] >>> FRAC_BITS;
        dsh[p][k]  = dp_q[p][k] >>> FRAC_BITS;
        dsum[p]    = dsum[p] + dsh[p][k][DT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int p = 0; p < 4; p++) begin
        dot_q[p] <= dsum[p];
        for (int k = 0; k < 3; k++) begin
          cr_q[p][k] <= csh[p][k][CR_W-1:0];
        end
      end
    end
  end

  // stage 4: magnitudes split in halves for the squares
  logic [CR_W-1:0]    cmag [4][3];
  logic [2*HH-1:0]    phh_q [4][3];
  logic [HH+HL-1:0]   phl_q [4][3];
  logic [2*HL-1:0]    pll_q [4][3];
  logic [CR_W-1:0]    dabs_q [4];
  logic               dneg_q [4];
  logic signed [DT_W-1:0] dotn [4];

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      dotn[p] = -dot_q[p];
      for (int k = 0; k < 3; k++) begin
        cmag[p][k] = cr_q[p][k][CR_W-1] ? CR_W'(-cr_q[p][k]) : cr_q[p][k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int p = 0; p < 4; p++) begin
        dneg_q[p] <= dot_q[p][DT_W-1];
        dabs_q[p] <= dot_q[p][DT_W-1] ? dotn[p][CR_W-1:0] : dot_q[p][CR_W-1:0];
        for (int k = 0; k < 3; k++) begin
          phh_q[p][k] <= cmag[p][k][CR_W-1:HL] * cmag[p][k][CR_W-1:HL];
          phl_q[p][k] <= cmag[p][k][CR_W-1:HL] * cmag[p][k][HL-1:0];
          pll_q[p][k] <= cmag[p][k][HL-1:0] * cmag[p][k][HL-1:0];
        end
      end
    end
  end

  // stage 5: squared norm of each cross product
  logic [SUM_W-1:0] sum_q [4];
  logic [SUM_W-1:0] ssum  [4];

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      ssum[p] = '0;
      for (int k = 0; k < 3; k++) begin
        ssum[p] = ssum[p] + (SUM_W'(phh_q[p][k]) << (2 * HL))
                          + (SUM_W'(phl_q[p][k]) << (HL + 1))
                          + SUM_W'(pll_q[p][k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q <= ssum;
    end
  end

  // sines, with the dot magnitudes following alongside
  logic [RT_W-1:0] sine [4];
  logic [CR_W-1:0] dabs_dl_q [RT_W+1][4];
  logic            dneg_dl_q [RT_W+1][4];

  for (genvar p = 0; p < 4; p++) begin : g_sqrt
    qbls_sqrt u_sqrt (
      .clk_i  (clk_i),
      .en_i   (en),
      .val_i  (sum_q[p]),
      .root_o (sine[p])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dabs_dl_q[0] <= dabs_q;
      dneg_dl_q[0] <= dneg_q;
      for (int s = 1; s <= RT_W; s++) begin
        dabs_dl_q[s] <= dabs_dl_q[s-1];
        dneg_dl_q[s] <= dneg_dl_q[s-1];
      end
    end
  end

  // cotangent magnitudes: (|dot| << F) / sine
  logic [Q_W-1:0]  cquo     [4];
  logic [RT_W-1:0] sine_dl_q [DIV_LAT][4];
  logic            cneg_dl_q [DIV_LAT][4];

  for (genvar p = 0; p < 4; p++) begin : g_cdiv
    qbls_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (NUM_W'(dabs_dl_q[RT_W][p]) << FRAC_BITS),
      .den_i (DEN_W'(sine[p])),
      .quo_o (cquo[p])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sine_dl_q[0] <= sine;
      cneg_dl_q[0] <= dneg_dl_q[RT_W];
      for (int s = 1; s < DIV_LAT; s++) begin
        sine_dl_q[s] <= sine_dl_q[s-1];
        cneg_dl_q[s] <= cneg_dl_q[s-1];
      end
    end
  end

  // stage 7: signed cotangents, area sum, degenerate flag
  logic signed [CO_W-1:0] cot_q [4];
  logic [AR_W-1:0]        ar_q  [5];
  logic                   dg_q  [5];
  logic [COT_W-1:0]       cm    [4];
  logic signed [CO_W-1:0] cv    [4];
  logic [AR_W-1:0]        area;

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      cm[p] = (cquo[p] > Q_W'({COT_W{1'b1}})) ? '1 : cquo[p][COT_W-1:0];
      cv[p] = {1'b0, cm[p]};
    end
    area = AR_W'(sine_dl_q[DIV_LAT-1][0]) + AR_W'(sine_dl_q[DIV_LAT-1][1]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int p = 0; p < 4; p++) begin
        cot_q[p] <= cneg_dl_q[DIV_LAT-1][p] ? -cv[p] : cv[p];
      end
      ar_q[0] <= area;
      dg_q[0] <= (sine_dl_q[DIV_LAT-1][0] == '0) || (sine_dl_q[DIV_LAT-1][1] == '0) ||
                 (sine_dl_q[DIV_LAT-1][2] == '0) || (sine_dl_q[DIV_LAT-1][3] == '0) ||
                 (area == '0);
      for (int s = 1; s < 5; s++) begin
        ar_q[s] <= ar_q[s-1];
        dg_q[s] <= dg_q[s-1];
      end
    end
  end

  // stage 8: K vector
  logic signed [K_W-1:0] k_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      k_q[0] <= K_W'(cot_q[2]) + K_W'(cot_q[3]);
      k_q[1] <= K_W'(cot_q[0]) + K_W'(cot_q[1]);
      k_q[2] <= -K_W'(cot_q[0]) - K_W'(cot_q[2]);
      k_q[3] <= -K_W'(cot_q[1]) - K_W'(cot_q[3]);
    end
  end

  // stage 9: magnitudes and signs of K
  logic [KA_W-1:0] kab_q [4];
  logic            kng_q [4];
  logic            kz_q  [4];
  logic signed [K_W-1:0] kn [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      kn[i] = -k_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        kab_q[i] <= k_q[i][K_W-1] ? kn[i] : k_q[i];
        kng_q[i] <= k_q[i][K_W-1];
        kz_q[i]  <= k_q[i] == '0;
      end
    end
  end

  // stage 10: |Ki|*|Kj| and entry signs
  logic [PR_W-1:0] pr_q  [NENT];
  logic            en_q  [NENT];
  logic            ez_q  [NENT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int n = 0; n < NENT; n++) begin
        pr_q[n] <= kab_q[ENT_ROW[n]] * kab_q[ENT_COL[n]];
        en_q[n] <= kng_q[ENT_ROW[n]] == kng_q[ENT_COL[n]];
        ez_q[n] <= kz_q[ENT_ROW[n]] || kz_q[ENT_COL[n]];
      end
    end
  end

  // stage 11: numerator 3*|Ki|*|Kj|
  logic [NUM_W-1:0] num_q [NENT];
  logic             eng2_q [NENT];
  logic             ez2_q  [NENT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int n = 0; n < NENT; n++) begin
        num_q[n]  <= (NUM_W'(pr_q[n]) << 1) + NUM_W'(pr_q[n]);
        eng2_q[n] <= en_q[n];
        ez2_q[n]  <= ez_q[n];
      end
    end
  end

  // entry magnitudes over the area sum
  logic [Q_W-1:0] emag [NENT];
  logic           eng_dl_q [DIV_LAT][NENT];
  logic           ez_dl_q  [DIV_LAT][NENT];
  logic           dg_dl_q  [DIV_LAT];

  for (genvar n = 0; n < NENT; n++) begin : g_ediv
    qbls_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_q[n]),
      .den_i (DEN_W'(ar_q[4])),
      .quo_o (emag[n])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      eng_dl_q[0] <= eng2_q;
      ez_dl_q[0]  <= ez2_q;
      dg_dl_q[0]  <= dg_q[4];
      for (int s = 1; s < DIV_LAT; s++) begin
        eng_dl_q[s] <= eng_dl_q[s-1];
        ez_dl_q[s]  <= ez_dl_q[s-1];
        dg_dl_q[s]  <= dg_dl_q[s-1];
      end
    end
  end

  // output register
  logic [OUT_W-1:0]       tdata_q;
  logic                   tuser_q;
  logic signed [ENT_W-1:0] ev [NENT];

  always_comb begin
    for (int n = 0; n < NENT; n++) begin
      ev[n] = {1'b0, emag[n]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int n = 0; n < NENT; n++) begin
        if (dg_dl_q[DIV_LAT-1] || ez_dl_q[DIV_LAT-1][n]) begin
          tdata_q[ENT_W*n +: ENT_W] <= '0;
        end else begin
          tdata_q[ENT_W*n +: ENT_W] <= eng_dl_q[DIV_LAT-1][n] ? -ev[n] : ev[n];
        end
      end
      tuser_q <= dg_dl_q[DIV_LAT-1];
    end
  end

  assign m_axis_tdata = tdata_q;
  assign m_axis_tuser = tuser_q;

  // a degenerate pair reports an all zero matrix
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("degenerate beat with nonzero entries");

  // diagonal entries are -3*Ki^2 over the area sum, never positive (q_00, q_33 checked)
  a_diag_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[ENT_W-1] || m_axis_tdata[ENT_W-1:0] == '0) &&
      (m_axis_tdata[ENT_W*NENT-1] || m_axis_tdata[ENT_W*NENT-1 -: ENT_W] == '0))
    else $error("positive diagonal entry");

  // a stall freezes every valid bit in the pipeline
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |=> $stable(vld_q))
    else $error("pipeline moved during stall");

endmodule

@@ rtl/qbls_sqrt.sv @@
module qbls_sqrt import qbls_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [SUM_W-1:0] val_i,
  output logic [RT_W-1:0]  root_o
);

  logic [SUM_W-1:0] rem_q  [RT_W];
  logic [RT_W-1:0]  root_q [RT_W];
  logic [SUM_W-1:0] rin    [RT_W];
  logic [RT_W-1:0]  oin    [RT_W];

  assign rin[0] = val_i;
  assign oin[0] = '0;

  // one root bit per stage, msb first; rem holds val minus root squared
  for (genvar g = 0; g < RT_W; g++) begin : g_stage
    localparam int B = RT_W - 1 - g;
    logic [TR_W-1:0] trial;
    logic            take;

    if (g > 0) begin : g_link
      assign rin[g] = rem_q[g-1];
      assign oin[g] = root_q[g-1];
    end

    assign trial = (TR_W'(oin[g]) << (B + 1)) | (TR_W'(1) << (2 * B));
    assign take  = trial <= TR_W'(rin[g]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= take ? rin[g] - trial[SUM_W-1:0] : rin[g];
        root_q[g] <= take ? (oin[g] | (RT_W'(1) << B)) : oin[g];
      end
    end
  end

  assign root_o = root_q[RT_W-1];

endmodule

@@ rtl/qbls_div.sv @@
module qbls_div import qbls_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quo_o
);

  logic [DEN_W-1:0] rem_q [Q_W+1];
  logic [Q_W-1:0]   low_q [Q_W+1];
  logic [Q_W-1:0]   quo_q [Q_W+1];
  logic [DEN_W-1:0] den_q [Q_W+1];
  logic             sat_q [Q_W+1];

  // quotient too wide for Q_W bits saturates to all ones
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_q[0] <= DEN_W'(num_i[NUM_W-1:Q_W]) >= den_i;
      rem_q[0] <= DEN_W'(num_i[NUM_W-1:Q_W]);
      low_q[0] <= num_i[Q_W-1:0];
      quo_q[0] <= '0;
      den_q[0] <= den_i;
    end
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_stage
    logic [DEN_W:0] trial;
    logic           take;

    assign trial = {rem_q[k-1], low_q[k-1][Q_W-1]};
    assign take  = trial >= {1'b0, den_q[k-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? DEN_W'(trial - {1'b0, den_q[k-1]}) : trial[DEN_W-1:0];
        low_q[k] <= low_q[k-1] << 1;
        quo_q[k] <= {quo_q[k-1][Q_W-2:0], take};
        den_q[k] <= den_q[k-1];
        sat_q[k] <= sat_q[k-1];
      end
    end
  end

  assign quo_o = sat_q[Q_W] ? '1 : quo_q[Q_W];

endmodule
